@@ hw/rtl/rvl_pkg.sv @@
// rvl_pkg: shared types, constants and the log table function for the
// realized variance unit. depends on nothing.
package rvl_pkg;

    localparam int STEP_W = 12;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 13;
    localparam int LP_W   = 32;
    localparam int L2_W   = 38;
    localparam int MAG_W  = 37;
    localparam int LO_W   = 19;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int LN2_W  = 29;
    localparam int TAB_W  = 31;
    localparam int QUE_DEPTH = 4;

    localparam logic [LN2_W-1:0] LN2_Q29  = 29'd372130559;
    localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_RESET = 12'd15;

    typedef struct packed {
        logic ok;
        logic kept;
        logic last;
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);

    typedef enum logic [3:0] {
        B_IDLE,
        B_DISPATCH,
        B_NORM,
        B_INTERP,
        B_L2,
        B_MLO,
        B_MHI,
        B_LN,
        B_SQ,
        B_ACC,
        B_EMIT
    } back_state_t;

    // log2(1 + k/2^bits) in q1.30 by repeated squaring
    function automatic logic [TAB_W-1:0] tab_entry(input int unsigned k,
                                                  input int unsigned bits);
        logic [63:0] x;
        logic [TAB_W-1:0] y;
        if (k >= (32'd1 << bits))
        begin
            return TAB_W'(64'd1 << 30);
        end
        x = (64'd1 << 30) + (64'(k) << (30 - bits));
        y = '0;
        for (int i = 1; i <= 30; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x = x >> 1;
                y[30 - i] = 1'b1;
            end
        end
        return y;
    endfunction

endpackage

@@ hw/rtl/rvl_ifs.sv @@
// rvl channel interfaces: sample input, result output, stride config.
// depends on nothing.
interface rvl_in_if #(parameter int PRICE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [PRICE_WIDTH-1:0] price;
    logic                   price_present;
    logic                   last_sample;
    modport source (output valid, price, price_present, last_sample, input ready);
    modport sink   (input valid, price, price_present, last_sample, output ready);
endinterface

interface rvl_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] realized_variance;
    logic        has_value;
    logic [12:0] return_count;
    modport source (output valid, realized_variance, has_value, return_count, input ready);
    modport sink   (input valid, realized_variance, has_value, return_count, output ready);
endinterface

interface rvl_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/rvl_queue.sv @@
// rvl_queue: small register fifo between front and back.
// depends on rvl_pkg.
module rvl_queue #(
    parameter int W     = 35,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);
    import rvl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
endmodule

@@ hw/rtl/rvl_front.sv @@
// rvl_front: takes sample beats, holds the stride and decimation phase,
// classifies each sample and pushes kept or last ones. depends on rvl_pkg.
module rvl_front #(
    parameter int PRICE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rvl_in_if.sink                            samples,
    rvl_cfg_if.sink                           cfg,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [PRICE_WIDTH+rvl_pkg::FLAGS_W-1:0] q_wdata
);
    import rvl_pkg::*;

    logic [STEP_W-1:0] step_reg, phase_reg, phase_next;
    logic [STEP_W-1:0] stride;
    logic [STEP_W:0]   phase_inc;
    logic              accept;
    flags_t            flags;

    assign cfg.ready     = 1'b1;
    assign samples.ready = !q_full;
    assign accept        = samples.valid && samples.ready;

    assign stride    = (step_reg == '0) ? STEP_W'(1) : step_reg;
    assign phase_inc = {1'b0, phase_reg} + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (samples.last_sample || (phase_inc >= {1'b0, stride}))
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_inc[STEP_W-1:0];
            end
        end
    end

    always_comb
    begin
        flags.kept = (phase_reg == '0);
        flags.ok   = samples.price_present && (samples.price != '0);
        flags.last = samples.last_sample;
    end

    assign q_push  = accept && (flags.kept || flags.last);
    assign q_wdata = {samples.price, flags};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_RESET;
            phase_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                step_reg <= cfg.data;
            end
            phase_reg <= phase_next;
        end
    end
endmodule

@@ hw/rtl/rvl_back.sv @@
// rvl_back: sequencer that takes queued samples, forms the fixed-point log,
// squares the return, accumulates and emits results. depends on rvl_pkg.
module rvl_back #(
    parameter int PRICE_WIDTH    = 32,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  logic [PRICE_WIDTH+rvl_pkg::FLAGS_W-1:0] q_rdata,
    output logic                              q_pop,
    rvl_out_if.source                         result
);
    import rvl_pkg::*;

    localparam int PW    = PRICE_WIDTH;
    localparam int TB    = LOG_TABLE_BITS;
    localparam int SH    = 31 - TB;
    localparam int MW    = $clog2(PW);
    localparam int TAB_N = 1 << TB;
    localparam int PR_W  = TAB_W + SH;

    logic [TAB_W-1:0] tab [TAB_N+1];

    for (genvar k = 0; k <= TAB_N; k++)
    begin : g_tab
        assign tab[k] = tab_entry(k, TB);
    end

    back_state_t state_reg, state_next;

    logic [PW-1:0]       price_reg, norm_reg;
    flags_t              flags_reg;
    logic [MW-1:0]       msb_reg;
    logic [PR_W-1:0]     prod_reg;
    logic [TAB_W-1:0]    t0_reg;
    logic                neg_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [LO_W+LN2_W-1:0] plo_reg;
    logic [HI_W+LN2_W-1:0] phi_reg;
    logic [LP_W-1:0]     lp_reg, prev_lp_reg;
    logic                prev_ok_reg;
    logic [SUM_W-1:0]    sq_reg, sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                ovalid_reg;
    logic [SUM_W-1:0]    orv_reg;
    logic                ohas_reg;
    logic [CNT_W-1:0]    ocnt_reg;

    logic                slot_free, emit;
    logic [PW+30:0]      ext;
    logic [30:0]         frac;
    logic [TB-1:0]       idx;
    logic [TB:0]         idx1;
    logic [SH-1:0]       rem;
    logic [TAB_W-1:0]    interp;
    logic signed [L2_W-1:0] l2;
    logic [L2_W-1:0]     l2_abs;
    logic [66:0]         tot;
    logic [34:0]         lnq;
    logic [LP_W-1:0]     lp_val;
    logic signed [LP_W:0] dif;
    logic [LP_W:0]       dmag;
    logic [2*LP_W+1:0]   dsq;
    logic [2*LP_W-13:0]  dsh;
    logic [SUM_W:0]      sum_add;

    assign slot_free = !ovalid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_DISPATCH;
                end
            end
            B_DISPATCH:
            begin
                if (flags_reg.kept && flags_reg.ok)
                begin
                    state_next = B_NORM;
                end
                else
                begin
                    state_next = flags_reg.last ? B_EMIT : B_IDLE;
                end
            end
            B_NORM:
            begin
                if (norm_reg[PW-1])
                begin
                    state_next = B_INTERP;
                end
            end
            B_INTERP: state_next = B_L2;
            B_L2:     state_next = B_MLO;
            B_MLO:    state_next = B_MHI;
            B_MHI:    state_next = B_LN;
            B_LN:     state_next = B_SQ;
            B_SQ:     state_next = B_ACC;
            B_ACC:    state_next = flags_reg.last ? B_EMIT : B_IDLE;
            B_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop = 1'b0;
        emit  = 1'b0;
        unique case (state_reg)
            B_IDLE:  q_pop = !q_empty;
            B_EMIT:  emit  = slot_free;
            default:
            begin
                q_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        ext    = {norm_reg, 31'b0};
        frac   = ext[PW+29 -: 31];
        idx    = frac[30 -: TB];
        idx1   = {1'b0, idx} + 1'b1;
        rem    = frac[SH-1:0];
        interp = t0_reg + TAB_W'(prod_reg >> SH);
        l2     = ($signed({{(L2_W-MW){1'b0}}, msb_reg}) - L2_W'(16)) * (L2_W'(1) << 30)
                 + $signed({{(L2_W-TAB_W){1'b0}}, interp});
        l2_abs = l2[L2_W-1] ? L2_W'(-l2) : L2_W'(l2);
        tot    = (67'(phi_reg) << LO_W) + 67'(plo_reg);
        lnq    = tot[66:32];
        if (!neg_reg)
        begin
            lp_val = (lnq > 35'h7FFFFFFF) ? 32'h7FFFFFFF : lnq[31:0];
        end
        else
        begin
            lp_val = (lnq > 35'h80000000) ? 32'h80000000 : (32'd0 - lnq[31:0]);
        end
        dif     = $signed({lp_reg[LP_W-1], lp_reg}) - $signed({prev_lp_reg[LP_W-1], prev_lp_reg});
        dmag    = dif[LP_W] ? (LP_W+1)'(-dif) : (LP_W+1)'(dif);
        dsq     = dmag * dmag;
        dsh     = dsq[2*LP_W+1:14];
        sum_add = {1'b0, sum_reg} + {1'b0, sq_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            prev_ok_reg <= 1'b0;
            prev_lp_reg <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_DISPATCH && flags_reg.kept && !flags_reg.ok)
            begin
                prev_ok_reg <= 1'b0;
                prev_lp_reg <= '0;
            end
            if (state_reg == B_ACC)
            begin
                if (prev_ok_reg)
                begin
                    sum_reg <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    if (cnt_reg != CNT_MAX)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                prev_ok_reg <= 1'b1;
                prev_lp_reg <= lp_reg;
            end
            if (emit)
            begin
                ovalid_reg  <= 1'b1;
                sum_reg     <= '0;
                cnt_reg     <= '0;
                prev_ok_reg <= 1'b0;
                prev_lp_reg <= '0;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            {price_reg, flags_reg} <= q_rdata;
        end
        if (state_reg == B_DISPATCH)
        begin
            norm_reg <= price_reg;
            msb_reg  <= MW'(PW - 1);
        end
        if (state_reg == B_NORM && !norm_reg[PW-1])
        begin
            norm_reg <= norm_reg << 1;
            msb_reg  <= msb_reg - 1'b1;
        end
        if (state_reg == B_INTERP)
        begin
            t0_reg   <= tab[{1'b0, idx}];
            prod_reg <= PR_W'(tab[idx1] - tab[{1'b0, idx}]) * PR_W'(rem);
        end
        if (state_reg == B_L2)
        begin
            neg_reg <= l2[L2_W-1];
            mag_reg <= l2_abs[MAG_W-1:0];
        end
        if (state_reg == B_MLO)
        begin
            plo_reg <= mag_reg[LO_W-1:0] * LN2_Q29;
        end
        if (state_reg == B_MHI)
        begin
            phi_reg <= mag_reg[MAG_W-1:LO_W] * LN2_Q29;
        end
        if (state_reg == B_LN)
        begin
            lp_reg <= lp_val;
        end
        if (state_reg == B_SQ)
        begin
            sq_reg <= (dsh > (2*LP_W-12)'(SUM_MAX)) ? SUM_MAX : dsh[SUM_W-1:0];
        end
        if (emit)
        begin
            orv_reg  <= (cnt_reg != '0) ? sum_reg : '0;
            ohas_reg <= (cnt_reg != '0);
            ocnt_reg <= cnt_reg;
        end
    end

    assign result.valid             = ovalid_reg;
    assign result.realized_variance = orv_reg;
    assign result.has_value         = ohas_reg;
    assign result.return_count      = ocnt_reg;

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (cnt_reg == '0) && (sum_reg == '0) && !prev_ok_reg)
        else $error("series state not cleared after result");
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_NORM) |-> (norm_reg != '0))
        else $error("normalizing a zero price");
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !emit |=> (cnt_reg >= $past(cnt_reg)))
        else $error("pair count dropped without a result");
endmodule

@@ hw/rtl/realized_variance_log_returns_unit.sv @@
// Realized variance of log returns over a decimated price series. Sample
// beats off the decimation grid that are not last end in the front. Kept
// samples and last samples go through a four-entry queue to a back sequencer:
// a kept present sample is normalized by one shift per leading zero of the
// price (up to PRICE_WIDTH-1 shifts), then interpolated, scaled to ln, squared
// and accumulated; a missing one skips these steps, and a last sample also
// loads the result register. The back sequencer sets the sustained rate for
// kept samples; stride sets how many cheap front beats sit between them.
// depends on rvl_pkg, rvl_ifs, rvl_front, rvl_queue, rvl_back.
module realized_variance_log_returns_unit #(
    parameter int PRICE_WIDTH    = 32,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    rvl_in_if.sink    samples,
    rvl_cfg_if.sink   cfg,
    rvl_out_if.source result
);
    import rvl_pkg::*;

    localparam int QW = PRICE_WIDTH + FLAGS_W;

    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    rvl_front #(.PRICE_WIDTH(PRICE_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    rvl_queue #(.W(QW), .DEPTH(QUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    rvl_back #(.PRICE_WIDTH(PRICE_WIDTH), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );
endmodule

@@ verif/rvl_tb_ifs.sv @@
`timescale 1ns / 100ps
// testbench package for the rvl channels: sample and result structs.
// depends on nothing.
package rvl_tb_pkg;
    typedef struct packed {
        logic [31:0] price;
        logic        present;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [47:0] variance;
        logic        has_value;
        logic [12:0] count;
    } rv_result_t;
endpackage

@@ verif/tb_realized_variance_log_returns_unit.sv @@
`timescale 1ns / 100ps
// testbench for realized_variance_log_returns_unit: queued random samples,
// bursty sender, stalling receiver, in-bench predictor of the series sums.
// depends on rvl_ifs, rvl_tb_pkg and realized_variance_log_returns_unit.
module tb_realized_variance_log_returns_unit;
    import rvl_tb_pkg::*;

    localparam int LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #2 clk = ~clk;

    rvl_in_if  #(.PRICE_WIDTH(32)) samples();
    rvl_out_if result();
    rvl_cfg_if cfg();

    realized_variance_log_returns_unit dut (
        .clk(clk), .rst_n(rst_n), .samples(samples.sink), .cfg(cfg.sink),
        .result(result.source)
    );

    sample_t    pending_samples[$];
    rv_result_t expected_sums[$];
    logic [30:0] ln_table[0:256];

    logic [11:0] stride_reg;
    logic [11:0] phase;
    logic [31:0] prev_ln;
    logic        prev_ok;
    logic [47:0] sum_acc;
    logic [12:0] pairs;

    int  errors = 0;
    int  cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_off = 0;
    bit  hold_req = 0;
    bit  stim_done = 0;

    function automatic logic [30:0] frac_log2(input logic [63:0] x0);
        logic [63:0] x;
        logic [30:0] y;
        x = x0;
        y = '0;
        for (int i = 1; i <= 30; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x = x >> 1;
                y[30 - i] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic logic signed [31:0] ln_q27(input logic [31:0] p);
        int msb;
        logic [63:0] frac, rem, mag, p64;
        logic [31:0] idx, interp;
        logic signed [63:0] l2;
        p64 = {32'd0, p};
        msb = 31;
        while (msb > 0 && !p64[msb])
            msb--;
        frac = (p64 << (31 - msb)) & 64'h7FFF_FFFF;
        idx = 32'(frac >> 23);
        rem = frac & 64'h7F_FFFF;
        interp = ln_table[idx] +
                 32'((64'(ln_table[idx + 1] - ln_table[idx]) * rem) >> 23);
        l2 = 64'(msb - 16) * 64'sd1073741824 + 64'(interp);
        if (l2 >= 0)
        begin
            mag = (64'(l2) * 64'd372130559) >> 32;
            if (mag > 64'h7FFF_FFFF)
                mag = 64'h7FFF_FFFF;
            return 32'(mag);
        end
        mag = (64'(-l2) * 64'd372130559) >> 32;
        if (mag > 64'h8000_0000)
            mag = 64'h8000_0000;
        return 32'(-64'(mag));
    endfunction

    task automatic predict_sample(input sample_t s);
        logic ok;
        logic signed [31:0] lp;
        logic signed [63:0] d;
        logic [63:0] m, sq;
        logic [48:0] total;
        logic [12:0] eff;
        eff = (stride_reg == 0) ? 12'd1 : stride_reg;
        if (phase == 0)
        begin
            ok = s.present && s.price != 0;
            lp = ok ? ln_q27(s.price) : 32'sd0;
            if (ok && prev_ok)
            begin
                d = 64'(lp) - 64'($signed(prev_ln));
                m = d < 0 ? -d : d;
                sq = (m * m) >> 14;
                if (sq > 64'hFFFF_FFFF_FFFF)
                    sq = 64'hFFFF_FFFF_FFFF;
                total = {1'b0, sum_acc} + sq[48:0];
                sum_acc = total[48] ? 48'hFFFF_FFFF_FFFF : total[47:0];
                if (pairs != 13'h1FFF)
                    pairs++;
            end
            prev_ok = ok;
            prev_ln = lp;
        end
        if (13'(phase) + 1 >= eff)
            phase = 0;
        else
            phase = phase + 1;
        if (s.last)
        begin
            expected_sums.push_back('{pairs != 0 ? sum_acc : 48'd0, pairs != 0, pairs});
            phase = 0;
            prev_ln = 0;
            prev_ok = 0;
            sum_acc = 0;
            pairs = 0;
        end
    endtask

    function automatic logic [31:0] rand_price();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return $urandom_range(1, 255);
            default: return 32'h10000 + $urandom_range(0, 32'h3FFFF);
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            void'(pending_samples.pop_front());
        if (!(samples.valid && !samples.ready))
        begin
            if (pending_samples.size() > (samples.valid && samples.ready ? 0 : 0)
                && burst_left > 0 && pending_samples.size() != 0)
            begin
                samples.valid <= 1'b1;
                {samples.price, samples.price_present, samples.last_sample}
                    <= pending_samples[0];
                burst_left <= burst_left - 1;
            end
            else
            begin
                samples.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rv_result_t want;
        cycles <= cycles + 1;
        if (result.valid && result.ready)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("unexpected result beat");
                errors <= errors + 1;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (result.realized_variance !== want.variance)
                begin
                    $error("realized_variance exp %0d got %0d", want.variance,
                           result.realized_variance);
                    errors <= errors + 1;
                end
                if (result.has_value !== want.has_value)
                begin
                    $error("has_value exp %0d got %0d", want.has_value, result.has_value);
                    errors <= errors + 1;
                end
                if (result.return_count !== want.count)
                begin
                    $error("return_count exp %0d got %0d", want.count, result.return_count);
                    errors <= errors + 1;
                end
            end
        end
        if (hold_req && hold_off == 0)
            hold_off <= 600;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ((cycles % 64) < 48) ? ($urandom_range(0, 3) != 0) : 1'b1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_sample(input logic [31:0] p, input logic pr, input logic l);
        sample_t s;
        s = '{p, pr, l};
        predict_sample(s);
        pending_samples.push_back(s);
    endtask

    task automatic write_stride(input logic [11:0] v);
        wait (pending_samples.size() == 0 && !samples.valid && expected_sums.size() == 0);
        repeat (60) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        stride_reg = v;
    endtask

    task automatic random_series(input int len);
        for (int i = 0; i < len; i++)
            queue_sample(rand_price(), $urandom_range(0, 7) != 0, i == len - 1);
    endtask

    initial
    begin
        logic [11:0] strides[6];
        int n;
        strides = '{12'd1, 12'd0, 12'd4095, 12'd2, 12'd3, 12'd15};
        for (int k = 0; k < 256; k++)
            ln_table[k] = frac_log2((64'd1 << 30) + (64'(k) << 22));
        ln_table[256] = 31'd1 << 30;
        samples.valid = 0;
        samples.price = 0;
        samples.price_present = 0;
        samples.last_sample = 0;
        result.ready = 0;
        cfg.valid = 0;
        cfg.data = 0;
        stride_reg = 12'd15;
        phase = 0;
        prev_ln = 0;
        prev_ok = 0;
        sum_acc = 0;
        pairs = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed, reset stride of 15
        queue_sample(32'd1, 1, 1);
        for (int i = 0; i < 16; i++)
            queue_sample(i == 0 ? 32'd1 : 32'hFFFF_FFFF, 1, i == 15);
        write_stride(12'd1);
        queue_sample(32'h10000, 1, 0);
        queue_sample(32'd0, 1, 0);
        queue_sample(32'h20000, 1, 0);
        queue_sample(32'h30000, 0, 0);
        queue_sample(32'h40000, 1, 0);
        queue_sample(32'h8000_0000, 1, 0);
        queue_sample(32'd1, 1, 1);
        write_stride(12'd0);
        queue_sample(32'd3, 1, 0);
        queue_sample(32'd5, 1, 1);
        hold_req = 1;
        for (int i = 0; i < 40; i++)
            queue_sample(rand_price(), 1, i == 39);
        wait (hold_off != 0);
        hold_req = 0;
        // mid-series stride change while idle
        write_stride(12'd4);
        for (int i = 0; i < 3; i++)
            queue_sample(32'h10000 + i, 1, 0);
        write_stride(12'd2);
        queue_sample(32'h20000, 1, 0);
        queue_sample(32'h30000, 1, 1);
        n = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_stride(strides[ph]);
            while (n < (ph + 1) * 75)
            begin
                int len;
                len = strides[ph] > 16 ? $urandom_range(1, 4) : $urandom_range(1, 24);
                random_series(len);
                n += len;
            end
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        wait (pending_samples.size() == 0 && expected_sums.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_sums.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
